[rtl/core/rht_pkg.sv]
`default_nettype none
package rht_pkg;
    localparam int HandleCount = 256;
    localparam int GroupSize = 16;
    localparam int GroupCount = HandleCount / GroupSize;
    localparam int SlotW = $clog2(HandleCount);
    localparam int GroupW = $clog2(GroupCount);
    localparam int MemberW = $clog2(GroupSize);
    localparam logic [15:0] RefcountLimit = 16'd65534;
    localparam logic [7:0] PinMax = 8'hff;
    localparam logic [15:0] PinSumMax = 16'hffff;
    localparam int QueueDepth = 2;

    typedef enum logic [2:0] {
        K_ALLOC = 3'd0, K_RETAIN = 3'd1, K_RELEASE = 3'd2,
        K_PIN = 3'd3, K_UNPIN = 3'd4, K_ACCESS = 3'd5,
        K_BAD6 = 3'd6, K_BAD7 = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NULL = 3'd1, ST_STATIC = 3'd2, ST_INVALID = 3'd3,
        ST_CAPACITY = 3'd4, ST_OVERFLOW = 3'd5, ST_INTERNAL = 3'd6,
        ST_SPARE = 3'd7
    } status_t;

    // A classified request as handed from the front to the back.
    typedef struct packed {
        kind_t kind;
        logic [15:0] handle;
        logic [31:0] addr;
        logic [7:0] obj_type;
        status_t pre_status;
        logic [SlotW-1:0] slot;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE, B_READ, B_WRITE
    } bstate_t;
endpackage
`default_nettype wire

[rtl/core/rht_stream_if.sv]
`default_nettype none
interface rht_in_if;
    logic valid;
    logic ready;
    logic [2:0] kind;
    logic [15:0] handle;
    logic [31:0] new_object_address;
    logic [7:0] obj_type;
    modport source (output valid, kind, handle, new_object_address, obj_type, input ready);
    modport sink (input valid, kind, handle, new_object_address, obj_type, output ready);
endinterface

interface rht_out_if;
    logic valid;
    logic ready;
    logic [2:0] status;
    logic [15:0] handle_out;
    logic [31:0] object_address;
    logic object_freed;
    logic [7:0] freed_type;
    logic [12:0] live_objects;
    logic [15:0] pins_total;
    modport source (output valid, status, handle_out, object_address, object_freed,
                    freed_type, live_objects, pins_total, input ready);
    modport sink (input valid, status, handle_out, object_address, object_freed,
                  freed_type, live_objects, pins_total, output ready);
endinterface
`default_nettype wire

[rtl/core/refcounted_handle_table_unit.sv]
`default_nettype none
// Reference-counted handle table.
// Requests enter on req (kind, handle, new_object_address, obj_type) and each
// produces exactly one item on rsp, in order. Both channels use valid/ready;
// an item moves on a clock edge where both are high.
// The front checks the kind and the null, static and range conditions and
// pushes the request into a two-entry queue. The back runs each request as a
// sequence: pick it up, read the table memories (and search the free bitmap
// for alloc), then update the entry and load the output register. It takes
// no new request until the current one is through, as the table memories get
// a single read-modify-write per request.
// Reset (rst_n low) empties the queue, marks every handle free and clears
// the live and pin totals; the memories need no clearing pass.
// When rsp stalls, the back holds its finished request until the output
// register is taken, then the queue fills and req ready drops.
module refcounted_handle_table_unit (
    input wire logic clk,
    input wire logic rst_n,
    rht_in_if.sink req,
    rht_out_if.source rsp
);
    import rht_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    cmd_t q_in, q_head;

    rht_front u_front (
        .in_ch(req),
        .q_full(q_full), .q_push(q_push), .q_data(q_in));

    rht_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in),
        .full(q_full), .pop(q_pop), .not_empty(q_valid), .head(q_head));

    rht_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head),
        .q_pop(q_pop), .out_ch(rsp));
endmodule
`default_nettype wire

[rtl/core/rht_ram.sv]
`default_nettype none
module rht_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(Depth)-1:0] waddr,
    input wire logic [Width-1:0] wdata,
    input wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0] rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/core/rht_front.sv]
`default_nettype none
module rht_front (
    rht_in_if.sink in_ch,
    input wire logic q_full,
    output logic q_push,
    output rht_pkg::cmd_t q_data
);
    import rht_pkg::*;

    logic [15:0] h;
    kind_t k;

    assign h = in_ch.handle;
    assign k = kind_t'(in_ch.kind);
    assign in_ch.ready = !q_full;
    assign q_push = in_ch.valid && !q_full;

    // Handle checks that need no table state; the back checks the used bit.
    always_comb
    begin
        q_data.kind = k;
        q_data.handle = h;
        q_data.addr = in_ch.new_object_address;
        q_data.obj_type = in_ch.obj_type;
        q_data.slot = SlotW'(h - 16'd1);
        priority if (k == K_ALLOC)
            q_data.pre_status = ST_OK;
        else if (k == K_BAD6 || k == K_BAD7)
            q_data.pre_status = ST_INTERNAL;
        else if (h == 16'd0)
            q_data.pre_status = (k == K_UNPIN) ? ST_INVALID : ST_NULL;
        else if (h[15])
            q_data.pre_status = ST_STATIC;
        else if (h > 16'(HandleCount))
            q_data.pre_status = ST_INVALID;
        else
            q_data.pre_status = ST_OK;
    end
endmodule
`default_nettype wire

[rtl/core/rht_queue.sv]
`default_nettype none
module rht_queue (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    input wire rht_pkg::cmd_t push_data,
    output logic full,
    input wire logic pop,
    output logic not_empty,
    output rht_pkg::cmd_t head
);
    import rht_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);
    cmd_t slots_reg [QueueDepth];
    logic [PtrW-1:0] wptr_reg, rptr_reg;
    logic [PtrW:0] count_reg;

    assign full = count_reg == (PtrW+1)'(QueueDepth);
    assign not_empty = count_reg != '0;
    assign head = slots_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[rtl/core/rht_back.sv]
`default_nettype none
module rht_back (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic q_valid,
    input wire rht_pkg::cmd_t q_head,
    output logic q_pop,
    rht_out_if.source out_ch
);
    import rht_pkg::*;

    bstate_t state_reg, state_next;
    cmd_t cmd_reg;
    logic [HandleCount-1:0] used_reg;
    logic [GroupCount-1:0] gfull_reg;
    logic [12:0] live_reg;
    logic [15:0] pins_reg;
    logic [SlotW-1:0] slot_reg;
    logic found_reg;
    logic ovalid_reg;
    logic [2:0] ostatus_reg;
    logic [15:0] ohandle_reg, opins_reg;
    logic [31:0] oaddr_reg;
    logic ofreed_reg;
    logic [7:0] otype_reg;
    logic [12:0] olive_reg;

    logic [31:0] addr_rd;
    logic [15:0] rc_rd;
    logic [7:0] pc_rd;
    logic we;
    logic mem_we;
    logic [31:0] addr_wd;
    logic [15:0] rc_wd;
    logic [7:0] pc_wd;

    // Two-level search for the lowest free slot.
    logic [GroupW-1:0] fgrp;
    logic [MemberW-1:0] fmem;
    logic fany;
    logic [GroupSize-1:0] gbits;
    always_comb
    begin
        fgrp = '0;
        fany = 1'b0;
        for (int g = GroupCount - 1; g >= 0; g--)
        begin
            if (!gfull_reg[g])
            begin
                fgrp = GroupW'(g);
                fany = 1'b1;
            end
        end
        gbits = used_reg[fgrp*GroupSize +: GroupSize];
        fmem = '0;
        for (int i = GroupSize - 1; i >= 0; i--)
        begin
            if (!gbits[i])
            begin
                fmem = MemberW'(i);
            end
        end
    end

    // The read address follows the request being executed, so the read data
    // stays put while the commit waits on the output register.
    rht_ram #(.Width(32), .Depth(HandleCount)) u_addr (
        .clk(clk), .we(mem_we), .waddr(slot_reg), .wdata(addr_wd),
        .raddr(cmd_reg.slot), .rdata(addr_rd));
    rht_ram #(.Width(16), .Depth(HandleCount)) u_rc (
        .clk(clk), .we(mem_we), .waddr(slot_reg), .wdata(rc_wd),
        .raddr(cmd_reg.slot), .rdata(rc_rd));
    rht_ram #(.Width(8), .Depth(HandleCount)) u_pc (
        .clk(clk), .we(mem_we), .waddr(slot_reg), .wdata(pc_wd),
        .raddr(cmd_reg.slot), .rdata(pc_rd));

    logic can_take;
    logic commit;
    assign can_take = !ovalid_reg || out_ch.ready;
    assign commit = (state_reg == B_WRITE) && can_take;
    assign mem_we = we && commit;
    assign q_pop = (state_reg == B_IDLE) && q_valid;

    // Execute-step results.
    status_t st;
    logic [31:0] a_out;
    logic [15:0] h_out;
    logic freed;
    logic used_set, used_clr;
    logic [12:0] live_n;
    logic [15:0] pins_n;
    logic [HandleCount-1:0] used_n;
    logic [GroupSize-1:0] grow;
    always_comb
    begin
        st = cmd_reg.pre_status;
        a_out = 32'd0;
        h_out = cmd_reg.handle;
        freed = 1'b0;
        we = 1'b0;
        addr_wd = addr_rd;
        rc_wd = rc_rd;
        pc_wd = pc_rd;
        used_set = 1'b0;
        used_clr = 1'b0;
        live_n = live_reg;
        pins_n = pins_reg;
        if (cmd_reg.kind == K_ALLOC)
        begin
            h_out = 16'd0;
            if (!found_reg)
            begin
                st = ST_CAPACITY;
            end
            else
            begin
                we = 1'b1;
                addr_wd = cmd_reg.addr;
                rc_wd = 16'd1;
                pc_wd = 8'd0;
                used_set = 1'b1;
                live_n = live_reg + 13'd1;
                h_out = 16'(slot_reg) + 16'd1;
                a_out = cmd_reg.addr;
            end
        end
        else if (st == ST_OK)
        begin
            if (!used_reg[slot_reg])
            begin
                st = ST_INVALID;
            end
            else
            begin
                unique case (cmd_reg.kind)
                    K_RETAIN:
                    begin
                        if (rc_rd >= RefcountLimit)
                            st = ST_OVERFLOW;
                        else
                        begin
                            we = 1'b1;
                            rc_wd = rc_rd + 16'd1;
                        end
                    end
                    K_PIN:
                    begin
                        if (pc_rd >= PinMax || rc_rd >= RefcountLimit || pins_reg >= PinSumMax)
                            st = ST_OVERFLOW;
                        else
                        begin
                            we = 1'b1;
                            rc_wd = rc_rd + 16'd1;
                            pc_wd = pc_rd + 8'd1;
                            pins_n = pins_reg + 16'd1;
                        end
                    end
                    K_RELEASE, K_UNPIN:
                    begin
                        pc_wd = pc_rd;
                        if (cmd_reg.kind == K_UNPIN)
                        begin
                            if (pc_rd == 8'd0)
                                st = ST_INVALID;
                            else
                                pc_wd = pc_rd - 8'd1;
                        end
                        if (st == ST_OK && (rc_rd == 16'd0 || rc_rd > RefcountLimit))
                            st = ST_INTERNAL;
                        if (st == ST_OK && rc_rd == 16'd1 && pc_wd != 8'd0)
                            st = ST_INTERNAL;
                        if (st == ST_OK)
                        begin
                            we = 1'b1;
                            if (cmd_reg.kind == K_UNPIN && pins_reg != 16'd0)
                                pins_n = pins_reg - 16'd1;
                            if (rc_rd > 16'd1)
                                rc_wd = rc_rd - 16'd1;
                            else
                            begin
                                rc_wd = 16'd0;
                                used_clr = 1'b1;
                                freed = 1'b1;
                                if (live_reg != 13'd0)
                                    live_n = live_reg - 13'd1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (st == ST_OK)
                    a_out = addr_rd;
            end
        end
        used_n = used_reg;
        if (used_set)
            used_n[slot_reg] = 1'b1;
        if (used_clr)
            used_n[slot_reg] = 1'b0;
        grow = used_n[slot_reg[SlotW-1:MemberW]*GroupSize +: GroupSize];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (q_valid) state_next = B_READ;
            B_READ: state_next = B_WRITE;
            B_WRITE: state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // B_WRITE waits for the output register to free up before it commits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            used_reg <= '0;
            gfull_reg <= '0;
            live_reg <= '0;
            pins_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg != B_WRITE || can_take)
                state_reg <= state_next;
            if (commit)
            begin
                used_reg <= used_n;
                gfull_reg[slot_reg[SlotW-1:MemberW]] <= &grow;
                live_reg <= live_n;
                pins_reg <= pins_n;
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
        if (state_reg == B_READ)
        begin
            if (cmd_reg.kind == K_ALLOC)
                slot_reg <= {fgrp, fmem};
            else
                slot_reg <= cmd_reg.slot;
            found_reg <= fany;
        end
        if (commit)
        begin
            ostatus_reg <= st;
            ohandle_reg <= h_out;
            oaddr_reg <= a_out;
            ofreed_reg <= freed;
            otype_reg <= freed ? cmd_reg.obj_type : 8'd0;
            olive_reg <= live_n;
            opins_reg <= pins_n;
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.status = ostatus_reg;
    assign out_ch.handle_out = ohandle_reg;
    assign out_ch.object_address = oaddr_reg;
    assign out_ch.object_freed = ofreed_reg;
    assign out_ch.freed_type = otype_reg;
    assign out_ch.live_objects = olive_reg;
    assign out_ch.pins_total = opins_reg;
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rht_pkg::*;

    typedef struct packed {
        logic [2:0] kind;
        logic [15:0] handle;
        logic [31:0] addr;
        logic [7:0] obj_type;
    } request_t;

    typedef struct packed {
        logic [2:0] status;
        logic [15:0] handle_out;
        logic [31:0] object_address;
        logic object_freed;
        logic [7:0] freed_type;
        logic [12:0] live_objects;
        logic [15:0] pins_total;
    } response_t;

    logic clk;
    logic rst_n;
    rht_in_if req ();
    rht_out_if rsp ();

    refcounted_handle_table_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source)
    );

    // Shadow copy of the table.
    logic slot_busy [HandleCount];
    logic [31:0] slot_addr [HandleCount];
    logic [15:0] slot_refs [HandleCount];
    logic [7:0] slot_pins [HandleCount];
    int unsigned shadow_live;
    int unsigned shadow_pins;

    request_t pending_requests [$];
    response_t expected_responses [$];
    int errors;
    int mismatches;
    int responses_seen;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    longint cycle_count;

    function automatic response_t table_apply(request_t r);
        response_t o;
        int s;
        int pa;
        logic [2:0] st;
        o = '0;
        o.handle_out = r.handle;
        st = ST_OK;
        if (r.kind == K_ALLOC)
        begin
            o.handle_out = '0;
            s = -1;
            for (int i = 0; i < HandleCount; i++)
                if (s < 0 && !slot_busy[i]) s = i;
            if (s < 0)
            begin
                st = ST_CAPACITY;
            end
            else
            begin
                slot_busy[s] = 1'b1;
                slot_addr[s] = r.addr;
                slot_refs[s] = 16'd1;
                slot_pins[s] = 8'd0;
                shadow_live++;
                o.handle_out = 16'(s + 1);
                o.object_address = r.addr;
            end
        end
        else if (r.kind <= K_ACCESS)
        begin
            if (r.handle == 0) st = ST_NULL;
            else if (r.handle[15]) st = ST_STATIC;
            else if (r.handle > HandleCount) st = ST_INVALID;
            else if (!slot_busy[r.handle - 1]) st = ST_INVALID;
            if (r.kind == K_UNPIN && st == ST_NULL) st = ST_INVALID;
            if (st == ST_OK)
            begin
                s = r.handle - 1;
                o.object_address = slot_addr[s];
                if (r.kind == K_RETAIN)
                begin
                    if (slot_refs[s] >= RefcountLimit) st = ST_OVERFLOW;
                    else slot_refs[s]++;
                end
                else if (r.kind == K_PIN)
                begin
                    if (slot_pins[s] >= PinMax || slot_refs[s] >= RefcountLimit
                        || shadow_pins >= PinSumMax)
                        st = ST_OVERFLOW;
                    else
                    begin
                        slot_refs[s]++;
                        slot_pins[s]++;
                        shadow_pins++;
                    end
                end
                else if (r.kind == K_RELEASE || r.kind == K_UNPIN)
                begin
                    pa = slot_pins[s];
                    if (r.kind == K_UNPIN)
                    begin
                        if (pa == 0) st = ST_INVALID;
                        else pa--;
                    end
                    if (st == ST_OK && (slot_refs[s] == 0 || slot_refs[s] > RefcountLimit))
                        st = ST_INTERNAL;
                    if (st == ST_OK && slot_refs[s] == 1 && pa != 0) st = ST_INTERNAL;
                    if (st == ST_OK)
                    begin
                        if (r.kind == K_UNPIN)
                        begin
                            slot_pins[s] = 8'(pa);
                            if (shadow_pins != 0) shadow_pins--;
                        end
                        if (slot_refs[s] > 1)
                        begin
                            slot_refs[s]--;
                        end
                        else
                        begin
                            slot_refs[s] = 0;
                            slot_busy[s] = 1'b0;
                            if (shadow_live != 0) shadow_live--;
                            o.object_freed = 1'b1;
                            o.freed_type = r.obj_type;
                        end
                    end
                end
                if (st != ST_OK) o.object_address = '0;
            end
        end
        else
        begin
            st = ST_INTERNAL;
        end
        o.status = st;
        o.live_objects = 13'(shadow_live);
        o.pins_total = 16'(shadow_pins);
        return o;
    endfunction

    function automatic logic [15:0] pick_handle();
        int unsigned c;
        c = $urandom_range(0, 99);
        if (c < 75) return 16'($urandom_range(1, 40));
        if (c < 80) return 16'd0;
        if (c < 85) return 16'($urandom_range(HandleCount + 1, 32767));
        if (c < 90) return 16'h8000 | 16'($urandom);
        return 16'($urandom_range(1, HandleCount));
    endfunction

    task automatic push_request(logic [2:0] k, logic [15:0] h, logic [31:0] a,
                                logic [7:0] t);
        request_t r;
        r.kind = k;
        r.handle = h;
        r.addr = a;
        r.obj_type = t;
        pending_requests.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Driver: each accepted item is predicted at the edge it moves.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.kind <= '0;
            req.handle <= '0;
            req.new_object_address <= '0;
            req.obj_type <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_responses.push_back(table_apply(pending_requests.pop_front()));
            end
            if (!req.valid || req.ready)
            begin
                if (pending_requests.size() > 0
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req.valid <= 1'b1;
                    req.kind <= pending_requests[0].kind;
                    req.handle <= pending_requests[0].handle;
                    req.new_object_address <= pending_requests[0].addr;
                    req.obj_type <= pending_requests[0].obj_type;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        response_t got;
        response_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.status = rsp.status;
            got.handle_out = rsp.handle_out;
            got.object_address = rsp.object_address;
            got.object_freed = rsp.object_freed;
            got.freed_type = rsp.freed_type;
            got.live_objects = rsp.live_objects;
            got.pins_total = rsp.pins_total;
            responses_seen++;
            if (expected_responses.size() == 0)
            begin
                errors++;
                if (mismatches < 10) $display("unexpected item %p", got);
                mismatches++;
            end
            else
            begin
                want = expected_responses.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int unsigned c;
        logic [2:0] k;
        errors = 0;
        mismatches = 0;
        responses_seen = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_live = 0;
        shadow_pins = 0;
        for (int i = 0; i < HandleCount; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_addr[i] = '0;
            slot_refs[i] = '0;
            slot_pins[i] = '0;
        end
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every kind, null, static, range and bad kinds.
        push_request(K_ALLOC, 16'hffff, 32'hffffffff, 8'hff);
        push_request(K_ALLOC, 16'h0, 32'h0, 8'h0);
        push_request(K_RETAIN, 16'd1, '0, '0);
        push_request(K_PIN, 16'd1, '0, '0);
        push_request(K_ACCESS, 16'd1, '0, '0);
        push_request(K_RELEASE, 16'd1, '0, 8'h5a);
        push_request(K_RELEASE, 16'd1, '0, 8'h5a);
        push_request(K_UNPIN, 16'd1, '0, 8'ha5);
        push_request(K_UNPIN, 16'd2, '0, 8'h11);
        push_request(K_RELEASE, 16'd2, '0, 8'hff);
        push_request(K_RETAIN, 16'd0, '0, '0);
        push_request(K_RELEASE, 16'd0, '0, '0);
        push_request(K_PIN, 16'd0, '0, '0);
        push_request(K_UNPIN, 16'd0, '0, '0);
        push_request(K_ACCESS, 16'd0, '0, '0);
        push_request(K_ACCESS, 16'h8001, '0, '0);
        push_request(K_RETAIN, 16'hffff, '0, '0);
        push_request(K_ACCESS, 16'(HandleCount + 1), '0, '0);
        push_request(K_ACCESS, 16'h7fff, '0, '0);
        push_request(K_BAD6, 16'd1, 32'h1234, 8'h1);
        push_request(K_BAD7, 16'd0, 32'h0, 8'h0);
        wait_drained();

        // Fill the table to capacity, then free a few in the middle.
        for (int i = 0; i < HandleCount + 2; i++)
            push_request(K_ALLOC, 16'($urandom), $urandom, 8'($urandom));
        push_request(K_RELEASE, 16'd100, '0, 8'h3c);
        push_request(K_RELEASE, 16'd17, '0, 8'hc3);
        push_request(K_ALLOC, '0, $urandom, '0);
        push_request(K_ALLOC, '0, $urandom, '0);
        // Pin-count saturation on one handle.
        for (int i = 0; i < 257; i++) push_request(K_PIN, 16'd5, '0, '0);
        push_request(K_RELEASE, 16'd5, '0, '0);
        wait_drained();
        // Release every handle once; the pinned one keeps most of its references.
        for (int h = 1; h <= HandleCount; h++)
            push_request(K_RELEASE, 16'(h), '0, 8'($urandom));
        wait_drained();

        // Random phases with different idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 80 : 12) : 0;
            recv_stall_pct = (ph == 2) ? 80 : (ph == 3 ? 12 : 0);
            if (ph == 0) hold_cycles = 300;
            for (int i = 0; i < 88; i++)
            begin
                c = $urandom_range(0, 99);
                if (c < 25) k = K_ALLOC;
                else if (c < 42) k = K_RETAIN;
                else if (c < 62) k = K_RELEASE;
                else if (c < 75) k = K_PIN;
                else if (c < 87) k = K_UNPIN;
                else if (c < 97) k = K_ACCESS;
                else k = 3'($urandom_range(6, 7));
                push_request(k, pick_handle(), $urandom, 8'($urandom));
            end
            wait_drained();
        end

        $display("testbench: %0d items checked over alloc, refcount, pin and fault paths,",
                 responses_seen);
        $display("testbench: with full-table, pin-saturation and backpressure phases");
        if (errors == 0 && expected_responses.size() == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: %0d mismatches", mismatches);
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/core/rht_pkg.sv
rtl/core/rht_stream_if.sv
rtl/core/rht_ram.sv
rtl/core/rht_front.sv
rtl/core/rht_queue.sv
rtl/core/rht_back.sv
rtl/core/refcounted_handle_table_unit.sv
tb/sv/testbench.sv
